FILE: rtl/vsc_pkg.sv
// Shared types and helpers for the stick constraint block.
`timescale 1ns / 1ps
`default_nettype none
package vsc_pkg;

  typedef struct packed {
    logic signed [31:0] point_a_x;
    logic signed [31:0] point_a_y;
    logic signed [31:0] point_b_x;
    logic signed [31:0] point_b_y;
    logic        [30:0] rest_length;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_a_x;
    logic signed [31:0] new_a_y;
    logic signed [31:0] new_b_x;
    logic signed [31:0] new_b_y;
    logic               degenerate;
  } out_item_t;

  // Values carried alongside the arithmetic through every stage before the output register.
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic        [30:0] rest;
  } carry_t;

  localparam int SQRT_STEPS = 33;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sh0_7FFF_FFFF;
    lo = -36'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/verlet_stick_constraint.sv
// Verlet stick distance constraint, fully pipelined.
//
// Input: one stick per transaction on in_data, taken when start is high and
// busy is low. busy is always low, so a stick may enter every cycle.
// Output: out_valid strobes for one cycle with the corrected end points on
// out_data. The receiver cannot stall; results are never held back.
// Stages in order: differences, squares, sum, root, divider setup, divider, product and
// the registered output. Throughput: one stick per cycle.
// The length is an integer square root, one result bit per stage over 33
// stages; the two direction components come from restoring dividers, one
// quotient bit per stage over FRAC_BITS + 1 stages.
// Coincident points pass through unchanged with degenerate set.
// Corrected coordinates saturate to the signed 32-bit range.
// Reset (rst_n low, synchronous) clears all stage valid bits; items in
// flight are dropped and no result appears until new sticks arrive.
`timescale 1ns / 1ps
`default_nettype none
module verlet_stick_constraint
  import vsc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  output out_item_t      out_data
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = 34 + FRAC_BITS;
  localparam int PW = 34 + QW;

  assign busy = 1'b0;

  // stage: differences and magnitudes
  logic        d_v_r;
  carry_t      d_pl_r;
  logic [32:0] d_mx_r, d_my_r;
  carry_t      d_pl_nxt;
  logic [32:0] d_mx_nxt, d_my_nxt;

  always_comb begin
    d_pl_nxt.ax   = in_data.point_a_x;
    d_pl_nxt.ay   = in_data.point_a_y;
    d_pl_nxt.bx   = in_data.point_b_x;
    d_pl_nxt.by   = in_data.point_b_y;
    d_pl_nxt.rest = in_data.rest_length;
    d_pl_nxt.dx   = 33'(in_data.point_b_x) - 33'(in_data.point_a_x);
    d_pl_nxt.dy   = 33'(in_data.point_b_y) - 33'(in_data.point_a_y);
    d_mx_nxt = d_pl_nxt.dx[32] ? 33'(-d_pl_nxt.dx) : 33'(d_pl_nxt.dx);
    d_my_nxt = d_pl_nxt.dy[32] ? 33'(-d_pl_nxt.dy) : 33'(d_pl_nxt.dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else begin
      d_v_r <= start & ~busy;
    end
    d_pl_r <= d_pl_nxt;
    d_mx_r <= d_mx_nxt;
    d_my_r <= d_my_nxt;
  end

  // stage: squares
  logic        s_v_r;
  carry_t      s_pl_r;
  logic [65:0] s_sx_r, s_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else begin
      s_v_r <= d_v_r;
    end
    s_pl_r <= d_pl_r;
    s_sx_r <= d_mx_r * d_mx_r;
    s_sy_r <= d_my_r * d_my_r;
  end

  // square root pipeline; entry 0 is the sum stage
  logic        q_v_r    [SQRT_STEPS+1];
  carry_t      q_pl_r   [SQRT_STEPS+1];
  logic [65:0] q_sum_r  [SQRT_STEPS+1];
  logic [35:0] q_rem_r  [SQRT_STEPS+1];
  logic [32:0] q_root_r [SQRT_STEPS+1];
  logic [35:0] q_rem_nxt  [SQRT_STEPS];
  logic [32:0] q_root_nxt [SQRT_STEPS];

  always_comb begin
    for (int j = 0; j < SQRT_STEPS; j++) begin
      logic [35:0] sh;
      logic [35:0] trial;
      logic [32:0] root2;
      sh    = {q_rem_r[j][33:0], q_sum_r[j][2*(SQRT_STEPS-1-j) +: 2]};
      root2 = {q_root_r[j][31:0], 1'b0};
      trial = {2'b00, root2, 1'b1};
      if (sh >= trial) begin
        q_rem_nxt[j]  = sh - trial;
        q_root_nxt[j] = root2 | 33'd1;
      end else begin
        q_rem_nxt[j]  = sh;
        q_root_nxt[j] = root2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= SQRT_STEPS; j++) q_v_r[j] <= 1'b0;
    end else begin
      q_v_r[0] <= s_v_r;
      for (int j = 0; j < SQRT_STEPS; j++) q_v_r[j+1] <= q_v_r[j];
    end
    q_pl_r[0]   <= s_pl_r;
    q_sum_r[0]  <= s_sx_r + s_sy_r;
    q_rem_r[0]  <= '0;
    q_root_r[0] <= '0;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      q_pl_r[j+1]   <= q_pl_r[j];
      q_sum_r[j+1]  <= q_sum_r[j];
      q_rem_r[j+1]  <= q_rem_nxt[j];
      q_root_r[j+1] <= q_root_nxt[j];
    end
  end

  // divider pipeline; entry 0 sets up the error and dividends
  logic          v_v_r   [QW+1];
  carry_t        v_pl_r  [QW+1];
  logic [32:0]   v_h_r   [QW+1];
  logic [33:0]   v_dm_r  [QW+1];
  logic          v_dn_r  [QW+1];
  logic          v_dg_r  [QW+1];
  logic [DW-1:0] v_rx_r  [QW+1];
  logic [DW-1:0] v_ry_r  [QW+1];
  logic [QW-1:0] v_qx_r  [QW+1];
  logic [QW-1:0] v_qy_r  [QW+1];

  carry_t             e_pl;
  logic [32:0]        e_h;
  logic signed [33:0] e_diff;
  logic [32:0]        e_mx, e_my;

  always_comb begin
    e_pl   = q_pl_r[SQRT_STEPS];
    e_h    = q_root_r[SQRT_STEPS];
    e_diff = 34'(e_pl.rest) - 34'(e_h);
    e_mx   = e_pl.dx[32] ? 33'(-e_pl.dx) : 33'(e_pl.dx);
    e_my   = e_pl.dy[32] ? 33'(-e_pl.dy) : 33'(e_pl.dy);
  end

  logic [DW-1:0] v_rx_nxt [QW];
  logic [DW-1:0] v_ry_nxt [QW];
  logic [QW-1:0] v_qx_nxt [QW];
  logic [QW-1:0] v_qy_nxt [QW];

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      logic [DW-1:0] ts;
      ts = DW'(v_h_r[j]) << (FRAC_BITS - j);
      if (v_rx_r[j] >= ts) begin
        v_rx_nxt[j] = v_rx_r[j] - ts;
        v_qx_nxt[j] = {v_qx_r[j][QW-2:0], 1'b1};
      end else begin
        v_rx_nxt[j] = v_rx_r[j];
        v_qx_nxt[j] = {v_qx_r[j][QW-2:0], 1'b0};
      end
      if (v_ry_r[j] >= ts) begin
        v_ry_nxt[j] = v_ry_r[j] - ts;
        v_qy_nxt[j] = {v_qy_r[j][QW-2:0], 1'b1};
      end else begin
        v_ry_nxt[j] = v_ry_r[j];
        v_qy_nxt[j] = {v_qy_r[j][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QW; j++) v_v_r[j] <= 1'b0;
    end else begin
      v_v_r[0] <= q_v_r[SQRT_STEPS];
      for (int j = 0; j < QW; j++) v_v_r[j+1] <= v_v_r[j];
    end
    v_pl_r[0] <= e_pl;
    v_h_r[0]  <= e_h;
    v_dm_r[0] <= e_diff[33] ? 34'(-e_diff) : 34'(e_diff);
    v_dn_r[0] <= e_diff[33];
    v_dg_r[0] <= (e_h == '0);
    v_rx_r[0] <= DW'(e_mx) << FRAC_BITS;
    v_ry_r[0] <= DW'(e_my) << FRAC_BITS;
    v_qx_r[0] <= '0;
    v_qy_r[0] <= '0;
    for (int j = 0; j < QW; j++) begin
      v_pl_r[j+1] <= v_pl_r[j];
      v_h_r[j+1]  <= v_h_r[j];
      v_dm_r[j+1] <= v_dm_r[j];
      v_dn_r[j+1] <= v_dn_r[j];
      v_dg_r[j+1] <= v_dg_r[j];
      v_rx_r[j+1] <= v_rx_nxt[j];
      v_ry_r[j+1] <= v_ry_nxt[j];
      v_qx_r[j+1] <= v_qx_nxt[j];
      v_qy_r[j+1] <= v_qy_nxt[j];
    end
  end

  // stage: error times direction
  logic          m_v_r;
  carry_t        m_pl_r;
  logic          m_dg_r;
  logic [PW-1:0] m_px_r, m_py_r;
  logic          m_nx_r, m_ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= v_v_r[QW];
    end
    m_pl_r <= v_pl_r[QW];
    m_dg_r <= v_dg_r[QW];
    m_px_r <= PW'(v_dm_r[QW]) * PW'(v_qx_r[QW]);
    m_py_r <= PW'(v_dm_r[QW]) * PW'(v_qy_r[QW]);
    m_nx_r <= v_dn_r[QW] ^ v_pl_r[QW].dx[32];
    m_ny_r <= v_dn_r[QW] ^ v_pl_r[QW].dy[32];
  end

  // stage: apply half offsets with saturation
  logic [33:0]        o_mx, o_my;
  logic signed [35:0] o_offx, o_offy;
  out_item_t          o_nxt;

  always_comb begin
    o_mx   = m_px_r[PW-1:QW];
    o_my   = m_py_r[PW-1:QW];
    o_offx = m_nx_r ? -36'(o_mx) : 36'(o_mx);
    o_offy = m_ny_r ? -36'(o_my) : 36'(o_my);
    if (m_dg_r) begin
      o_nxt.new_a_x = m_pl_r.ax;
      o_nxt.new_a_y = m_pl_r.ay;
      o_nxt.new_b_x = m_pl_r.bx;
      o_nxt.new_b_y = m_pl_r.by;
    end else begin
      o_nxt.new_a_x = sat32(36'(m_pl_r.ax) - o_offx);
      o_nxt.new_a_y = sat32(36'(m_pl_r.ay) - o_offy);
      o_nxt.new_b_x = sat32(36'(m_pl_r.bx) + o_offx);
      o_nxt.new_b_y = sat32(36'(m_pl_r.by) + o_offy);
    end
    o_nxt.degenerate = m_dg_r;
  end

  logic      out_v_r;
  out_item_t out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= m_v_r;
    end
    out_d_r <= o_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule
`default_nettype wire

FILE: rtl/vsc_checker.sv
// Port-level checker for the stick constraint block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module vsc_checker
  import vsc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire out_item_t out_data
);

  localparam int LAT = FRAC_BITS + 40;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without transaction");

  a_degen_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.degenerate ==
      ($past(in_data.point_a_x, LAT) == $past(in_data.point_b_x, LAT) &&
       $past(in_data.point_a_y, LAT) == $past(in_data.point_b_y, LAT)))
    else $error("degenerate flag wrong");

  a_degen_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.new_a_x == $past(in_data.point_a_x, LAT) &&
      out_data.new_b_y == $past(in_data.point_b_y, LAT))
    else $error("coincident points altered");

endmodule

bind verlet_stick_constraint vsc_checker #(.FRAC_BITS(FRAC_BITS)) u_vsc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
);
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the Verlet stick constraint block.
`timescale 1ns / 1ps
module tb;
  import vsc_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 40;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;

  int fail_count = 0;
  int sticks_sent = 0;
  int degen_seen = 0;
  int idle_cycles = 0;
  bit done = 1'b0;

  always #4 clk = ~clk;

  verlet_stick_constraint #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Bitwise integer square root of a 66-bit value.
  function automatic logic [32:0] root66(input logic [65:0] v);
    logic [67:0] rem;
    logic [34:0] root;
    logic [67:0] trial;
    rem = '0;
    root = '0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | v[2*k +: 2];
      root = root << 1;
      trial = {root, 1'b1};
      if (rem >= trial) begin
        rem = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root[32:0];
  endfunction

  function automatic logic signed [63:0] half_shift(input logic signed [63:0] diff,
                                                    input logic signed [63:0] u);
    logic [127:0] m;
    logic [63:0] ad;
    logic [63:0] au;
    ad = diff < 0 ? -diff : diff;
    au = u < 0 ? -u : u;
    m = (128'(ad) * 128'(au)) >> (FRAC + 1);
    return ((diff < 0) != (u < 0)) ? -$signed(m[63:0]) : $signed(m[63:0]);
  endfunction

  function automatic out_item_t correct_stick(input in_item_t s);
    out_item_t r;
    logic signed [63:0] dx, dy, h, diff, ux, uy, ox, oy;
    logic [65:0] sq;
    dx = 64'(s.point_b_x) - 64'(s.point_a_x);
    dy = 64'(s.point_b_y) - 64'(s.point_a_y);
    sq = 66'(dx < 0 ? -dx : dx) ** 2 + 66'(dy < 0 ? -dy : dy) ** 2;
    h = 64'(root66(sq));
    r = {s.point_a_x, s.point_a_y, s.point_b_x, s.point_b_y, 1'b0};
    if (h == 0) begin
      r.degenerate = 1'b1;
    end else begin
      diff = 64'(s.rest_length) - h;
      ux = (dx * (64'sd1 <<< FRAC)) / h;
      uy = (dy * (64'sd1 <<< FRAC)) / h;
      ox = half_shift(diff, ux);
      oy = half_shift(diff, uy);
      r.new_a_x = clamp32(64'(s.point_a_x) - ox);
      r.new_a_y = clamp32(64'(s.point_a_y) - oy);
      r.new_b_x = clamp32(64'(s.point_b_x) + ox);
      r.new_b_y = clamp32(64'(s.point_b_y) + oy);
    end
    return r;
  endfunction

  class stick_scoreboard;
    out_item_t pending[$];

    function void note_stick(input in_item_t s);
      pending.push_back(correct_stick(s));
    endfunction

    task check_result(input out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("UNEXPECTED result %h at %0t", got, $realtime);
        fail_count++;
        return;
      end
      want = pending.pop_front();
      if (got.new_a_x !== want.new_a_x) report_mismatch("new_a_x", got.new_a_x, want.new_a_x);
      if (got.new_a_y !== want.new_a_y) report_mismatch("new_a_y", got.new_a_y, want.new_a_y);
      if (got.new_b_x !== want.new_b_x) report_mismatch("new_b_x", got.new_b_x, want.new_b_x);
      if (got.new_b_y !== want.new_b_y) report_mismatch("new_b_y", got.new_b_y, want.new_b_y);
      if (got.degenerate !== want.degenerate)
        report_mismatch("degenerate", 32'(got.degenerate), 32'(want.degenerate));
    endtask
  endclass

  stick_scoreboard sb = new();

  // Input and output sampling at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_stick(in_data);
        sticks_sent++;
      end
      if (out_valid) begin
        if (out_data.degenerate) degen_seen++;
        sb.check_result(out_data);
      end
      idle_cycles = ((start && !busy) || out_valid) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !done) begin
        $display("watchdog expired at %0t", $realtime);
        $display("tb failed");
        $finish;
      end
    end
  end

  // Present one stick; hold start through the acceptance edge.
  task automatic send_stick(input in_item_t s, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    start <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 65536)
                                     : 32'h8000_0000 + $urandom_range(0, 65536);
      default: return 32'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  function automatic in_item_t rand_stick();
    in_item_t s;
    logic signed [31:0] dx, dy;
    s.point_a_x = rand_coord();
    s.point_a_y = rand_coord();
    case ($urandom_range(0, 7))
      0: begin
        s.point_b_x = s.point_a_x;
        s.point_b_y = s.point_a_y;
      end
      1, 2, 3: begin
        // nearby point: a realistic stick
        dx = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        dy = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        s.point_b_x = s.point_a_x + dx;
        s.point_b_y = s.point_a_y + dy;
      end
      4: begin
        s.point_b_x = s.point_a_x + $signed($urandom_range(0, 2)) - 1;
        s.point_b_y = s.point_a_y + $signed($urandom_range(0, 2)) - 1;
      end
      default: begin
        s.point_b_x = rand_coord();
        s.point_b_y = rand_coord();
      end
    endcase
    case ($urandom_range(0, 3))
      0: s.rest_length = 31'($urandom());
      1: s.rest_length = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
      default: s.rest_length = 31'($urandom_range(0, 1 << 23));
    endcase
    return s;
  endfunction

  initial begin
    in_item_t dir[$];
    in_item_t s;
    int gap;
    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MAXN = 32'h8000_0000;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: coincident points, extremes, stretched, compressed, saturation.
    dir.push_back('{0, 0, 0, 0, 0});
    dir.push_back('{MAXP, MAXN, MAXP, MAXN, 31'h7FFF_FFFF});
    dir.push_back('{MAXN, MAXN, MAXP, MAXP, 0});
    dir.push_back('{MAXN, MAXN, MAXP, MAXP, 31'h7FFF_FFFF});
    dir.push_back('{MAXP, MAXP, MAXN, MAXN, 31'h7FFF_FFFF});
    dir.push_back('{MAXN, 0, MAXP, 0, 31'h7FFF_FFFF});
    dir.push_back('{0, MAXN, 0, MAXP, 0});
    dir.push_back('{0, 0, 32'h0003_0000, 32'h0004_0000, 31'h0005_0000});
    dir.push_back('{0, 0, 32'h0003_0000, 32'h0004_0000, 31'h000A_0000});
    dir.push_back('{0, 0, 32'h0003_0000, 32'h0004_0000, 31'h0001_0000});
    dir.push_back('{0, 0, 1, 0, 0});
    dir.push_back('{0, 0, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF});
    dir.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5});
    dir.push_back('{32'h0001_0000, 32'hFFFF_0000, 32'hFFFE_0000, 32'h0002_0000, 31'h1});
    dir.push_back('{32'h7FFF_0000, 0, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF});
    dir.push_back('{32'h8000_FFFF, 0, 32'h8000_0000, 0, 31'h7FFF_FFFF});
    dir.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA});
    foreach (dir[i]) send_stick(dir[i], i % 3);

    // Let the pipeline drain completely once before the random part.
    stop_sending();
    while (sb.pending.size() != 0) @(negedge clk);

    for (int n = 0; n < 1600; n++) begin
      s = rand_stick();
      gap = ((n / 200) % 2 == 0) ? 0 : $urandom_range(0, 6);
      if (n == 800) begin
        stop_sending();
        while (sb.pending.size() != 0) @(negedge clk);
      end
      send_stick(s, gap);
    end
    stop_sending();

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    done = 1'b1;

    $display("Sent %0d sticks (directed extremes plus random), %0d coincident-point results.",
             sticks_sent, degen_seen);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
